// ----- hdl/apl_pkg.sv -----
// Shared types, constants and the arctangent table for the accelerometer pitch block.
package apl_pkg;

    // Field and datapath widths
    localparam int AY_W       = 21;  // accel sample field
    localparam int NUM_W      = 22;  // numerator / divisor after offset
    localparam int OFS_W      = 18;  // offset registers
    localparam int ALPHA_W    = 17;  // lpf_alpha register
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int ANG_W      = 18;  // CORDIC angle, 2^-15 rad
    localparam int RAW_W      = 19;  // angle after pitch offset
    localparam int XY_W       = 41;  // CORDIC x/y, 16 fraction bits
    localparam int FRAC       = 16;
    localparam int F_W        = 35;  // filter state
    localparam int FL_W       = 17;  // low part of the split state multiply
    localparam int FH_W       = F_W - FL_W;
    localparam int MUL_A_W    = 19;
    localparam int MUL_B_W    = ALPHA_W + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = F_W + MUL_B_W - 1;
    localparam int SUM_W      = 38;
    localparam int PITCH_W    = 19;
    localparam int PW_W       = F_W + 1 - FRAC;  // rounded pitch before clamp

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;

    localparam logic signed [NUM_W-1:0]   SMALL_ACCEL = 22'sd41;
    localparam logic signed [ANG_W-1:0]   HALF_PI     = 18'sd51472;
    localparam logic [ALPHA_W-1:0]        ALPHA_ONE   = 17'd65536;
    localparam logic [ALPHA_W-1:0]        ALPHA_RESET = 17'd6554;
    localparam logic signed [F_W-1:0]     F_MAX       = {1'b0, {(F_W-1){1'b1}}};
    localparam logic signed [F_W-1:0]     F_MIN       = {1'b1, {(F_W-1){1'b0}}};
    localparam logic signed [F_W:0]       ROUND_HALF  = (F_W+1)'(32768);
    localparam logic signed [PW_W-1:0]    PITCH_MAX   = PW_W'(262143);
    localparam logic signed [PW_W-1:0]    PITCH_MIN   = -PW_W'(262144);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENSOR_ENABLED = 3'd0,
        REG_CALIBRATED     = 3'd1,
        REG_OFFSET_Y       = 3'd2,
        REG_OFFSET_Z       = 3'd3,
        REG_PITCH_OFFSET   = 3'd4,
        REG_LPF_ALPHA      = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_ITER,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_ACC,
        S_DONE
    } apl_state_t;

    typedef struct packed {
        logic               sensor_enabled;
        logic               calibrated;
        logic [OFS_W-1:0]   offset_y;
        logic [OFS_W-1:0]   offset_z;
        logic [OFS_W-1:0]   pitch_offset;
        logic [ALPHA_W-1:0] lpf_alpha;
    } apl_cfg_t;

    typedef struct packed {
        logic              load;      // sample word accepted
        logic              prerot;    // quadrant fold into right half plane
        logic              iter;      // one CORDIC step
        logic [STEP_W-1:0] step;
        logic              mul0;      // f low * alpha
        logic              mul1;      // f high * alpha
        logic              mul2;      // raw * alpha
        logic              acc;       // filter update
        logic              load_out;  // write result register
    } apl_cmd_t;

    typedef struct packed {
        logic skip;
        logic out_free;
    } apl_stat_t;

    // round(atan(2^-i) * 2^15)
    function automatic logic signed [ANG_W-1:0] atan_tab(input logic [STEP_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            4'd0:  v = 18'sd25736;
            4'd1:  v = 18'sd15193;
            4'd2:  v = 18'sd8027;
            4'd3:  v = 18'sd4075;
            4'd4:  v = 18'sd2045;
            4'd5:  v = 18'sd1024;
            4'd6:  v = 18'sd512;
            4'd7:  v = 18'sd256;
            4'd8:  v = 18'sd128;
            4'd9:  v = 18'sd64;
            4'd10: v = 18'sd32;
            4'd11: v = 18'sd16;
            4'd12: v = 18'sd8;
            4'd13: v = 18'sd4;
            4'd14: v = 18'sd2;
            4'd15: v = 18'sd1;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/apl_ifs.sv -----
// Handshake interfaces for sample, result and configuration words.
interface apl_in_if import apl_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [AY_W-1:0] accel_y;
    logic signed [AY_W-1:0] accel_z;

    modport source (output valid, output accel_y, output accel_z, input ready);
    modport sink   (input valid, input accel_y, input accel_z, output ready);
endinterface

interface apl_out_if import apl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [PITCH_W-1:0] pitch;
    logic                      updated;

    modport source (output valid, output pitch, output updated, input ready);
    modport sink   (input valid, input pitch, input updated, output ready);
endinterface

interface apl_cfg_if import apl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/apl_regs.sv -----
// Configuration register bank.
module apl_regs import apl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    apl_cfg_if.sink   cfg,
    output apl_cfg_t  regs
);

    apl_cfg_t regs_reg;
    apl_cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SENSOR_ENABLED: regs_next.sensor_enabled = cfg.data[0];
                REG_CALIBRATED:     regs_next.calibrated     = cfg.data[0];
                REG_OFFSET_Y:       regs_next.offset_y       = cfg.data[OFS_W-1:0];
                REG_OFFSET_Z:       regs_next.offset_z       = cfg.data[OFS_W-1:0];
                REG_PITCH_OFFSET:   regs_next.pitch_offset   = cfg.data[OFS_W-1:0];
                REG_LPF_ALPHA:      regs_next.lpf_alpha      = cfg.data[ALPHA_W-1:0];
                default:            regs_next = regs_reg;  // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.sensor_enabled <= 1'b0;
            regs_reg.calibrated     <= 1'b0;
            regs_reg.offset_y       <= '0;
            regs_reg.offset_z       <= '0;
            regs_reg.pitch_offset   <= '0;
            regs_reg.lpf_alpha      <= ALPHA_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- hdl/apl_ctrl.sv -----
// Sequencer: steps one sample through fold, CORDIC, multiplies and filter update.
module apl_ctrl import apl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_ready,
    input  apl_stat_t stat,
    output apl_cmd_t  cmd
);

    apl_state_t        state_reg;
    apl_state_t        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        sample_ready = 1'b0;
        cmd          = '0;
        cmd.step     = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                step_next = '0;
                if (stat.skip)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.prerot = 1'b1;
                    state_next = S_ITER;
                end
            end
            S_ITER:
            begin
                cmd.iter  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd.mul0   = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/apl_dpath.sv -----
// Datapath: axis select, CORDIC vectoring, shared multiplier, IIR filter, result register.
module apl_dpath import apl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [AY_W-1:0]    accel_y,
    input  logic signed [AY_W-1:0]    accel_z,
    input  apl_cfg_t                  regs,
    input  apl_cmd_t                  cmd,
    output apl_stat_t                 stat,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [PITCH_W-1:0] out_pitch,
    output logic                      out_updated
);

    // item registers
    logic                      skip_reg,    skip_next;
    logic signed [NUM_W-1:0]   num_reg,     num_next;
    logic signed [NUM_W-1:0]   den_reg,     den_next;
    logic signed [XY_W-1:0]    x_reg,       x_next;
    logic signed [XY_W-1:0]    y_reg,       y_next;
    logic signed [ANG_W-1:0]   ang_reg,     ang_next;
    logic signed [RAW_W-1:0]   raw_reg,     raw_next;
    logic signed [PROD_W-1:0]  prod_reg,    prod_next;
    logic signed [ACC_W-1:0]   acc_reg,     acc_next;
    // filter state and result
    logic signed [F_W-1:0]     f_reg,       f_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [PITCH_W-1:0] pitch_reg,   pitch_next;
    logic                      updated_reg, updated_next;

    logic signed [NUM_W-1:0]   ay_x, az_x, num_c, den_c;
    logic                      small_y, small_z;
    logic signed [XY_W-1:0]    xn, yn, xs, ys;
    logic [ALPHA_W-1:0]        alpha_sat;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_c;
    logic signed [SUM_W-1:0]   sum_c;
    logic signed [F_W:0]       rnd_c;
    logic signed [PW_W-1:0]    pw_c;

    assign stat.skip     = skip_reg;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_pitch     = pitch_reg;
    assign out_updated   = updated_reg;

    // sample front end: skip test, axis select, divisor pinning
    always_comb
    begin
        ay_x    = NUM_W'(accel_y);
        az_x    = NUM_W'(accel_z);
        small_y = (ay_x > -SMALL_ACCEL) && (ay_x < SMALL_ACCEL);
        small_z = (az_x > -SMALL_ACCEL) && (az_x < SMALL_ACCEL);
        if (regs.calibrated)
        begin
            num_c = -ay_x - NUM_W'($signed(regs.offset_y));
            den_c = az_x - NUM_W'($signed(regs.offset_z));
        end
        else
        begin
            num_c = ay_x;
            den_c = -az_x;
        end
        if ((den_c > -SMALL_ACCEL) && (den_c < SMALL_ACCEL))
        begin
            den_c = den_c[NUM_W-1] ? -SMALL_ACCEL : SMALL_ACCEL;
        end
    end

    // shared 19x18 multiplier, operand picked by the sequencer
    always_comb
    begin
        alpha_sat = (regs.lpf_alpha > ALPHA_ONE) ? ALPHA_ONE : regs.lpf_alpha;
        mul_b     = $signed({1'b0, alpha_sat});
        if (cmd.mul0)
        begin
            mul_a = $signed({{(MUL_A_W-FL_W){1'b0}}, f_reg[FL_W-1:0]});
        end
        else if (cmd.mul1)
        begin
            mul_a = MUL_A_W'($signed(f_reg[F_W-1:FL_W]));
        end
        else
        begin
            mul_a = raw_reg;
        end
        prod_c = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_comb
    begin
        xn    = XY_W'(den_reg) <<< FRAC;
        yn    = XY_W'(num_reg) <<< FRAC;
        xs    = x_reg >>> cmd.step;
        ys    = y_reg >>> cmd.step;
        // f - floor(f*a/2^16) + a*raw, before clamping
        sum_c = SUM_W'(f_reg) - SUM_W'(acc_reg >>> FRAC) + SUM_W'(prod_reg);
        rnd_c = (F_W+1)'(f_reg) + ROUND_HALF;
        pw_c  = rnd_c[F_W:FRAC];
    end

    always_comb
    begin
        skip_next      = skip_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        ang_next       = ang_reg;
        raw_next       = raw_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        f_next         = f_reg;
        pitch_next     = pitch_reg;
        updated_next   = updated_reg;
        out_valid_next = out_valid_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            skip_next = !regs.sensor_enabled || (small_y && small_z);
            num_next  = num_c;
            den_next  = den_c;
        end

        if (cmd.prerot)
        begin
            if (!den_reg[NUM_W-1])
            begin
                x_next   = xn;
                y_next   = yn;
                ang_next = '0;
            end
            else if (!num_reg[NUM_W-1])
            begin
                x_next   = yn;
                y_next   = -xn;
                ang_next = HALF_PI;
            end
            else
            begin
                x_next   = -yn;
                y_next   = xn;
                ang_next = -HALF_PI;
            end
        end

        if (cmd.iter)
        begin
            if (!y_reg[XY_W-1])
            begin
                x_next   = x_reg + ys;
                y_next   = y_reg - xs;
                ang_next = ang_reg + atan_tab(cmd.step);
            end
            else
            begin
                x_next   = x_reg - ys;
                y_next   = y_reg + xs;
                ang_next = ang_reg - atan_tab(cmd.step);
            end
        end

        if (cmd.mul0)
        begin
            raw_next  = regs.calibrated
                      ? RAW_W'(ang_reg) - RAW_W'($signed(regs.pitch_offset))
                      : RAW_W'(ang_reg);
            prod_next = prod_c;
        end

        if (cmd.mul1)
        begin
            acc_next  = ACC_W'(prod_reg);
            prod_next = prod_c;
        end

        if (cmd.mul2)
        begin
            acc_next  = acc_reg + (ACC_W'(prod_reg) <<< FL_W);
            prod_next = prod_c;
        end

        if (cmd.acc)
        begin
            if (sum_c > SUM_W'(F_MAX))
            begin
                f_next = F_MAX;
            end
            else if (sum_c < SUM_W'(F_MIN))
            begin
                f_next = F_MIN;
            end
            else
            begin
                f_next = sum_c[F_W-1:0];
            end
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            updated_next   = !skip_reg;
            if (skip_reg)
            begin
                pitch_next = '0;
            end
            else if (pw_c > PITCH_MAX)
            begin
                pitch_next = PITCH_MAX[PITCH_W-1:0];
            end
            else if (pw_c < PITCH_MIN)
            begin
                pitch_next = PITCH_MIN[PITCH_W-1:0];
            end
            else
            begin
                pitch_next = pw_c[PITCH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        skip_reg    <= skip_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        ang_reg     <= ang_next;
        raw_reg     <= raw_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        pitch_reg   <= pitch_next;
        updated_reg <= updated_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            f_reg         <= f_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("result register written while still holding a word");

    a_state_only_on_acc: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.acc |=> $stable(f_reg))
        else $error("filter state changed outside the update step");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load_out))
        else $error("result valid raised without a result load");

    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !updated_reg) |-> (pitch_reg == '0))
        else $error("skipped word carries a nonzero pitch");
`endif

endmodule

// ----- hdl/accel_pitch_lowpass_core.sv -----
// Top level of the accelerometer pitch estimator with IIR low-pass.
//
// Each sample word (accel_y, accel_z at 2^-12 m/s^2) yields exactly one result
// word: a filtered pitch at 2^-15 rad and an updated flag. When the sensor is
// disabled or both axes are below 41 LSB in magnitude the result is zero with
// updated low, and the filter state is left alone. Otherwise the axes are
// selected (y raw and z negated, or offset-corrected with y negated when
// calibrated), the divisor is pinned to at least 41 LSB in magnitude, atan2
// is taken with a 16-step CORDIC in vectoring mode, the pitch offset is
// removed when calibrated, and the 35-bit IIR state f is updated as
// f - floor(f*a/2^16) + a*angle. Timing: the block handles one sample at a
// time. An updating sample passes from acceptance through the quadrant fold,
// the 16 iterations of the single CORDIC stage, three passes through the
// shared 19x18 multiplier, the filter update and the result load before its
// result is presented; a skipped sample goes from the skip test straight to
// the result load. The sequencer is back in idle in the cycle after the
// result load. sample.ready is high whenever the sequencer is idle, even while
// a previous result still waits in the output register; the sequencer only
// stalls at its final step if that register is still occupied. Configuration
// writes are always taken (cfg.ready is tied high) and must only be issued
// while the block is idle; indexes beyond the last register are ignored.
module accel_pitch_lowpass_core import apl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    apl_in_if.sink     sample,
    apl_out_if.source  result,
    apl_cfg_if.sink    cfg
);

    apl_cfg_t  regs;
    apl_cmd_t  cmd;
    apl_stat_t stat;

    // register bank, written through the cfg channel
    apl_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // sequencer; owns sample.ready
    apl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // arithmetic and the output word register
    apl_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .accel_y     (sample.accel_y),
        .accel_z     (sample.accel_z),
        .regs        (regs),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .out_pitch   (result.pitch),
        .out_updated (result.updated)
    );

endmodule
